@@ design/bba_pkg.sv @@
package bba_pkg;

  // Default geometry. MAP_WORD_BITS must be a power of two.
  localparam int NUM_BLOCKS_DEF    = 4096;
  localparam int MAP_WORD_BITS_DEF = 8;

  localparam int CFG_W    = 13;
  localparam int BLOCK_W  = 12;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK           = 2'd0,
    STS_NO_FREE      = 2'd1,
    STS_ALREADY_FREE = 2'd2,
    STS_OUT_OF_RANGE = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    clr_step;
    logic    latch_op;
    logic    scan_init;
    logic    rd_free;
    logic    rd_scan;
    logic    wr_word;
    logic    rsp_vld;
    status_e rsp_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic func_free;
    logic out_of_range;
    logic limit_zero;
    logic scan_issue_ok;
    logic chk_vld;
    logic chk_last;
    logic found;
    logic bit_set;
  } sts_t;

endpackage

@@ design/bba_ctrl.sv @@
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_CHECK   = 5'b00100,
    S_FREE_WR = 5'b01000,
    S_SCAN    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rsp_status = STS_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch_op = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.func_free) begin
          if (sts_i.out_of_range) begin
            cmd_o.rsp_vld    = 1'b1;
            cmd_o.rsp_status = STS_OUT_OF_RANGE;
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_free = 1'b1;
            state_d = S_FREE_WR;
          end
        end else if (sts_i.limit_zero) begin
          cmd_o.rsp_vld    = 1'b1;
          cmd_o.rsp_status = STS_NO_FREE;
          state_d = S_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_FREE_WR: begin
        cmd_o.rsp_vld = 1'b1;
        if (sts_i.bit_set) begin
          cmd_o.wr_word    = 1'b1;
          cmd_o.rsp_status = STS_OK;
        end else begin
          cmd_o.rsp_status = STS_ALREADY_FREE;
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.chk_vld && sts_i.found) begin
          cmd_o.wr_word    = 1'b1;
          cmd_o.rsp_vld    = 1'b1;
          cmd_o.rsp_status = STS_OK;
          state_d = S_IDLE;
        end else if (sts_i.chk_vld && sts_i.chk_last) begin
          cmd_o.rsp_vld    = 1'b1;
          cmd_o.rsp_status = STS_NO_FREE;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_scan = sts_i.scan_issue_ok;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ design/bba_dpath.sv @@
module bba_dpath
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                func_i,
  input  logic [BLOCK_W-1:0]  block_number_i,
  input  logic                cfg_valid_i,
  input  logic [CFG_W-1:0]    cfg_blocks_in_use_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                done_o,
  output logic [BLOCK_W-1:0]  result_block_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int MAP_DEPTH = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SHIFT     = $clog2(MAP_WORD_BITS);
  localparam int SCAN_W    = ADDR_W + 1;

  logic [MAP_WORD_BITS-1:0] mem [MAP_DEPTH];

  logic [CFG_W-1:0]         cfg_q;
  func_e                    func_q;
  logic [BLOCK_W-1:0]       block_q;
  logic [ADDR_W-1:0]        clr_addr_q;
  logic [SCAN_W-1:0]        scan_addr_q;
  logic [MAP_WORD_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]        chk_addr_q;
  logic                     chk_vld_q;
  logic                     done_q;
  logic [BLOCK_W-1:0]       result_q;
  status_e                  status_q;

  logic [CFG_W-1:0]         limit;
  logic [31:0]              lim_m1;
  logic [ADDR_W-1:0]        last_word;
  logic [SHIFT-1:0]         last_bit;
  logic [MAP_WORD_BITS-1:0] word_mask;
  logic [MAP_WORD_BITS-1:0] cand;
  logic [SHIFT-1:0]         found_pos;
  logic [31:0]              blk32;
  logic [ADDR_W-1:0]        free_word;
  logic [SHIFT-1:0]         free_bit;
  logic [MAP_WORD_BITS-1:0] bit_mask;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data;
  logic [ADDR_W+SHIFT-1:0]  found_block;

  // Counts above capacity act as the capacity
  assign limit     = (32'(cfg_q) > 32'(NUM_BLOCKS)) ? CFG_W'(NUM_BLOCKS) : cfg_q;
  assign lim_m1    = 32'(limit) - 32'd1;
  assign last_word = lim_m1[SHIFT +: ADDR_W];
  assign last_bit  = lim_m1[SHIFT-1:0];

  assign blk32     = 32'(block_q);
  assign free_word = blk32[SHIFT +: ADDR_W];
  assign free_bit  = blk32[SHIFT-1:0];

  // Drop bits at or above the count in the last word
  always_comb begin
    word_mask = '1;
    if (chk_addr_q == last_word) begin
      word_mask = {MAP_WORD_BITS{1'b1}} >> (SHIFT'(MAP_WORD_BITS - 1) - last_bit);
    end
  end

  assign cand = ~rdata_q & word_mask;

  always_comb begin
    found_pos = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found_pos = SHIFT'(j);
      end
    end
  end

  assign found_block = {chk_addr_q, found_pos};

  assign bit_mask = (func_q == FUNC_FREE) ? (MAP_WORD_BITS'(1) << free_bit)
                                          : (MAP_WORD_BITS'(1) << found_pos);

  assign rd_en   = cmd_i.rd_free | cmd_i.rd_scan;
  assign rd_addr = cmd_i.rd_free ? free_word : scan_addr_q[ADDR_W-1:0];

  assign wr_en   = cmd_i.clr_step | cmd_i.wr_word;
  assign wr_addr = cmd_i.clr_step ? clr_addr_q : chk_addr_q;
  always_comb begin
    if (cmd_i.clr_step) begin
      wr_data = '0;
    end else if (func_q == FUNC_FREE) begin
      wr_data = rdata_q & ~bit_mask;
    end else begin
      wr_data = rdata_q | bit_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    chk_addr_q <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_op) begin
      func_q  <= func_e'(func_i);
      block_q <= block_number_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      clr_addr_q  <= '0;
      scan_addr_q <= '0;
      chk_vld_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_blocks_in_use_i;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.scan_init) begin
        scan_addr_q <= '0;
      end else if (cmd_i.rd_scan) begin
        scan_addr_q <= scan_addr_q + SCAN_W'(1);
      end
      chk_vld_q <= rd_en;
      done_q    <= cmd_i.rsp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_vld) begin
      status_q <= cmd_i.rsp_status;
      if (cmd_i.rsp_status != STS_OK) begin
        result_q <= '0;
      end else if (func_q == FUNC_FREE) begin
        result_q <= block_q;
      end else begin
        result_q <= BLOCK_W'(found_block);
      end
    end
  end

  always_comb begin
    sts_o               = '0;
    sts_o.clr_last      = (clr_addr_q == ADDR_W'(MAP_DEPTH - 1));
    sts_o.func_free     = (func_q == FUNC_FREE);
    sts_o.out_of_range  = ({1'b0, block_q} >= limit);
    sts_o.limit_zero    = (limit == '0);
    sts_o.scan_issue_ok = (scan_addr_q <= {1'b0, last_word});
    sts_o.chk_vld       = chk_vld_q;
    sts_o.chk_last      = (chk_addr_q == last_word);
    sts_o.found         = |cand;
    sts_o.bit_set       = |(rdata_q & bit_mask);
  end

  assign done_o         = done_q;
  assign result_block_o = result_q;
  assign status_o       = status_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("bitmap word read and written in the same cycle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_scan |-> (scan_addr_q <= {1'b0, last_word}))
    else $error("scan read beyond the last word of the count");

  a_alloc_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rsp_vld && cmd_i.rsp_status == STS_OK && func_q == FUNC_ALLOC)
      |-> (32'(found_block) < 32'(limit)))
    else $error("allocated block at or above the count");

  a_err_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STS_OK) |-> (result_q == '0))
    else $error("error result carries a nonzero block");

  a_write_has_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_word |-> ##1 (done_q && status_q == STS_OK))
    else $error("bitmap updated without an ok result");

endmodule

@@ design/bitmap_block_allocator.sv @@
// Channel   Direction  Signals                                     Transfer
// command   in         start_i, busy_o, func_i, block_number_i     start_i && !busy_o
// result    out        done_o, result_block_o, status_o            done_o, one cycle
// config    in         cfg_valid_i, cfg_ready_o, cfg_blocks_in_use_i  valid && ready
//
// After reset the bitmap store is cleared one word a cycle, with busy_o high until
// every word is clear; config is taken meanwhile.
// A free goes through a check, then a read-modify-write of one bitmap word.
// An allocate checks, then scans the bitmap words from word 0 up to the word holding the first
// free block, or up to the last word of the count when none is free; an error found at the check ends it there.
// The result is strobed for one cycle as busy_o falls; the receiver cannot stall it.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS    = NUM_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command transfer
  input  logic                start_i,
  output logic                busy_o,
  input  logic                func_i,
  input  logic [BLOCK_W-1:0]  block_number_i,
  // result transfer
  output logic                done_o,
  output logic [BLOCK_W-1:0]  result_block_o,
  output logic [STATUS_W-1:0] status_o,
  // block count register
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_blocks_in_use_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_write;

  // The count register is always ready; hold off writes only by the caller
  // keeping to idle periods.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // Sequencer: clear pass, command decode, free check and first-fit scan
  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Bitmap store, scan counters, bit search and result registers
  bba_dpath #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .func_i              (func_i),
    .block_number_i      (block_number_i),
    .cfg_valid_i         (cfg_write),
    .cfg_blocks_in_use_i (cfg_blocks_in_use_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .done_o              (done_o),
    .result_block_o      (result_block_o),
    .status_o            (status_o)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam int     NBLK          = NUM_BLOCKS_DEF;
  localparam int     IDLE_PCT      = 33;
  localparam int     RAND_ITEMS    = 1600;
  // Longest allocate scans every bitmap word of the count; allow a margin on top.
  localparam int     SETTLE_CYCLES = 600;
  localparam longint CYCLE_LIMIT   = 4000000;

  typedef enum logic [1:0] {
    ENT_CMD,
    ENT_CFG,
    ENT_DRAIN
  } entry_kind_e;

  typedef struct {
    entry_kind_e        kind;
    func_e              fn;
    logic [BLOCK_W-1:0] blk;
    logic [CFG_W-1:0]   cnt;
    bit                 steady;
  } stim_entry_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] blk;
    status_e            sts;
  } outcome_t;

  logic                clk_i               = 1'b0;
  logic                rst_ni              = 1'b0;
  logic                start_i             = 1'b0;
  logic                func_i              = 1'b0;
  logic [BLOCK_W-1:0]  block_number_i      = '0;
  logic                cfg_valid_i         = 1'b0;
  logic [CFG_W-1:0]    cfg_blocks_in_use_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [BLOCK_W-1:0]  result_block_o;
  logic [STATUS_W-1:0] status_o;
  logic                cfg_ready_o;

  // Own copy of the allocator state: one bit per block and the block count register.
  bit               block_used [NBLK];
  logic [CFG_W-1:0] block_count = CFG_RESET;

  stim_entry_t cmd_backlog[$];      // stimulus still to be offered, in order
  outcome_t    pending_results[$];  // outcomes of accepted commands, oldest first
  int unsigned cmds_accepted = 0;   // written by the driver only
  int unsigned results_seen  = 0;   // written by the monitor only, nonblocking
  int unsigned mismatches    = 0;
  longint      cycle_count   = 0;
  bit          steady_run    = 1'b0;

  bitmap_block_allocator DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .func_i             (func_i),
    .block_number_i     (block_number_i),
    .done_o             (done_o),
    .result_block_o     (result_block_o),
    .status_o           (status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_blocks_in_use_i(cfg_blocks_in_use_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset low from time zero, then release it for good.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // First-fit allocate or free against the local bitmap; returns block and status.
  function automatic outcome_t serve_request(func_e fn, logic [BLOCK_W-1:0] blk);
    int       lim;
    outcome_t res;
    // A count above capacity behaves as full capacity.
    lim = (block_count > NBLK) ? NBLK : int'(block_count);
    res.blk = '0;
    res.sts = STS_NO_FREE;
    if (fn == FUNC_ALLOC) begin
      for (int b = 0; b < lim; b++) begin
        if (!block_used[b]) begin
          block_used[b] = 1'b1;
          res.blk = BLOCK_W'(b);
          res.sts = STS_OK;
          return res;
        end
      end
    end else if (int'(blk) >= lim) begin
      // Blocks at or above the count keep their bits but cannot be touched.
      res.sts = STS_OUT_OF_RANGE;
    end else if (!block_used[blk]) begin
      res.sts = STS_ALREADY_FREE;
    end else begin
      block_used[blk] = 1'b0;
      res.blk = blk;
      res.sts = STS_OK;
    end
    return res;
  endfunction

  task automatic queue_cmd(func_e fn, logic [BLOCK_W-1:0] blk);
    stim_entry_t e;
    e.kind   = ENT_CMD;
    e.fn     = fn;
    e.blk    = blk;
    e.cnt    = '0;
    e.steady = steady_run;
    cmd_backlog.push_back(e);
  endtask

  task automatic queue_cfg(logic [CFG_W-1:0] cnt);
    stim_entry_t e;
    e.kind   = ENT_CFG;
    e.fn     = FUNC_ALLOC;
    e.blk    = '0;
    e.cnt    = cnt;
    e.steady = steady_run;
    cmd_backlog.push_back(e);
  endtask

  task automatic queue_drain();
    stim_entry_t e;
    e.kind   = ENT_DRAIN;
    e.fn     = FUNC_ALLOC;
    e.blk    = '0;
    e.cnt    = '0;
    e.steady = steady_run;
    cmd_backlog.push_back(e);
  endtask

  // Driver: retire whatever transferred at this edge, then choose what to offer next.
  // Each driven signal gets at most one nonblocking assignment per edge.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit want_start;
    bit want_cfg;
    if (!rst_ni) begin
      start_i     <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      want_start = 1'b0;
      want_cfg   = 1'b0;
      // Command transfer: predict the outcome now, in acceptance order.
      if (start_i && !busy_o) begin
        pending_results.push_back(serve_request(func_e'(func_i), block_number_i));
        cmds_accepted++;
        void'(cmd_backlog.pop_front());
      end
      // Register transfer: only ever offered while the block is idle.
      if (cfg_valid_i && cfg_ready_o) begin
        block_count = cfg_blocks_in_use_i;
        void'(cmd_backlog.pop_front());
      end
      if (cmd_backlog.size() != 0) begin
        case (cmd_backlog[0].kind)
          ENT_CMD: begin
            // Idle at random unless inside the steady stretch; start may drop while busy.
            want_start     = cmd_backlog[0].steady || ($urandom_range(99) >= IDLE_PCT);
            func_i         <= cmd_backlog[0].fn;
            block_number_i <= cmd_backlog[0].blk;
          end
          ENT_CFG: begin
            // Wait until every outstanding result has come back.
            want_cfg = (cmds_accepted == results_seen) && !busy_o &&
                       (cmd_backlog[0].steady || ($urandom_range(99) >= IDLE_PCT));
            cfg_blocks_in_use_i <= cmd_backlog[0].cnt;
          end
          default: begin
            // Pause: offer nothing until the block has drained.
            if (cmds_accepted == results_seen) void'(cmd_backlog.pop_front());
          end
        endcase
      end
      start_i     <= want_start;
      cfg_valid_i <= want_cfg;
    end
  end

  // Monitor: every strobed result is compared with the oldest outstanding outcome.
  always @(posedge clk_i) begin : check_proc
    outcome_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none outstanding: expected nothing, got block %0d status %0d",
                 $time, result_block_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (result_block_o !== want.blk) begin
          mismatches++;
          $display("%0t: result_block mismatch: expected %0d, got %0d",
                   $time, want.blk, result_block_o);
        end
        if (status_o !== want.sts) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d (%s), got %0d",
                   $time, want.sts, want.sts.name(), status_o);
        end
      end
    end
  end

  // Guard against a hung block: allows for the clearing pass and worst-case scans.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int               n_rand;
    int               eff;
    int               r;
    int               alloc_pct;
    int               phase_len;
    int               hi;
    logic [CFG_W-1:0] cnt;
    logic [BLOCK_W-1:0] blk;

    // Directed: default count of 4096 after reset, empty bitmap.
    queue_cmd(FUNC_FREE, 12'd0);        // free of a free block
    queue_cmd(FUNC_ALLOC, 12'd4095);    // block number ignored on allocate
    queue_cmd(FUNC_ALLOC, 12'd0);
    queue_cmd(FUNC_ALLOC, 12'd0);
    queue_cmd(FUNC_FREE, 12'd1);
    queue_cmd(FUNC_ALLOC, 12'd0);       // first fit takes block 1 back
    queue_cmd(FUNC_FREE, 12'd4095);     // top block, never allocated
    queue_cmd(FUNC_FREE, 12'd2048);
    queue_drain();
    // Count of three with blocks 0..2 used: bitmap full within range.
    queue_cfg(13'd3);
    queue_cmd(FUNC_ALLOC, 12'd0);
    queue_cmd(FUNC_FREE, 12'd3);        // out of range
    queue_cmd(FUNC_FREE, 12'd2);
    queue_cmd(FUNC_ALLOC, 12'd0);
    // Count of zero: nothing can be allocated or freed.
    queue_cfg(13'd0);
    queue_cmd(FUNC_ALLOC, 12'd0);
    queue_cmd(FUNC_FREE, 12'd0);
    // Count above capacity acts as full capacity.
    queue_cfg(13'd8191);
    queue_cmd(FUNC_FREE, 12'd4095);
    queue_cmd(FUNC_ALLOC, 12'd0);       // block 3
    // Lowered count: block 3 keeps its bit but is out of reach.
    queue_cfg(13'd1);
    queue_cmd(FUNC_FREE, 12'd3);
    queue_cmd(FUNC_ALLOC, 12'd0);
    queue_cfg(13'd4096);
    queue_cmd(FUNC_FREE, 12'd3);
    queue_cmd(FUNC_FREE, 12'd0);

    // Random phases: a count, then a burst of allocates and frees around it.
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      // Run a long stretch with no idling at all.
      steady_run = (n_rand >= 500 && n_rand < 850);
      r = $urandom_range(99);
      if (r < 60) begin
        cnt = CFG_W'($urandom_range(1, 64));
      end else if (r < 85) begin
        cnt = CFG_W'($urandom_range(65, 600));
      end else begin
        case ($urandom_range(6))
          0:       cnt = 13'd0;
          1:       cnt = 13'd1;
          2:       cnt = 13'd4095;
          3:       cnt = 13'd4096;
          4:       cnt = 13'd4097;
          5:       cnt = 13'd8191;
          default: cnt = 13'd2048;
        endcase
      end
      queue_cfg(cnt);
      eff       = (cnt > NBLK) ? NBLK : int'(cnt);
      alloc_pct = $urandom_range(30, 80);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        if ($urandom_range(99) < alloc_pct) begin
          queue_cmd(FUNC_ALLOC, BLOCK_W'($urandom()));
        end else begin
          // Aim most frees at the low blocks where allocations land.
          r = $urandom_range(99);
          if (eff != 0 && r < 75) begin
            hi  = (eff < 128) ? eff : 128;
            blk = BLOCK_W'($urandom_range(0, hi - 1));
          end else if (r < 90) begin
            hi  = (eff + 16 > NBLK - 1) ? NBLK - 1 : eff + 16;
            blk = BLOCK_W'($urandom_range(0, hi));
          end else begin
            blk = BLOCK_W'($urandom_range(0, NBLK - 1));
          end
          queue_cmd(FUNC_FREE, blk);
        end
        if ($urandom_range(99) < 3) queue_drain();
        n_rand++;
      end
    end

    // Drain: wait for the backlog and all results, then let the block settle.
    while (cmd_backlog.size() != 0 || cmds_accepted != results_seen) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: results missing: expected %0d more, got none",
               $time, pending_results.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
